@@ hdl/setq_pkg.sv @@
`timescale 1ns / 1ps
// setq_pkg: request codes, field widths and controller/datapath interface structs
// shared by every module of the sorted expiry timer queue; depends on nothing

package setq_pkg;

	localparam int TIME_W   = 32;
	localparam int ID_W     = 4;
	localparam int REQ_W    = 2;
	localparam int ID_SPACE = 16;
	localparam int CNT_W    = 5;

	localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ARM     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CANCEL  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_PROCESS = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load_req;
		logic time_inc;
		logic pos_clear;
		logic pos_inc;
		logic remove_at_pos;
		logic set_expiry;
		logic insert_at_pos;
		logic capture_pend;
		logic push_out;
		logic push_last;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [REQ_W-1:0]    req;
		logic                id_ok;
		logic                armed;
		logic                pos_match;
		logic                ins_here;
		logic                head_due;
		logic                out_free;
		logic                pend_valid;
		logic [CNT_W-1:0]    armed_cnt;
		logic [ID_SPACE-1:0] armed_mask;
	} ctrl_sts_t;

endpackage

@@ hdl/setq_datapath.sv @@
`timescale 1ns / 1ps
// setq_datapath: time counter, expiry registers, ordered id list, armed mask and
// the result register; driven by commands from setq_ctrl, uses setq_pkg

module setq_datapath #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  setq_pkg::ctrl_cmd_t           cmd,
	output setq_pkg::ctrl_sts_t           sts,
	input  logic [setq_pkg::REQ_W-1:0]    req_type,
	input  logic [setq_pkg::ID_W-1:0]     timer_id,
	input  logic [setq_pkg::TIME_W-1:0]   interval,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [setq_pkg::ID_W-1:0]     expired_id,
	output logic                          last_flag
);
	import setq_pkg::*;

	localparam int LIST_DEPTH = (NUM_SLOTS < ID_SPACE) ? NUM_SLOTS : ID_SPACE;
	localparam int IW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic [TIME_W-1:0]   time_q;
	logic [TIME_W-1:0]   exp_q [LIST_DEPTH];
	logic [ID_W-1:0]     order_q [LIST_DEPTH];
	logic [CW-1:0]       cnt_q;
	logic [ID_SPACE-1:0] mask_q;
	logic [REQ_W-1:0]    req_q;
	logic [ID_W-1:0]     id_q;
	logic [TIME_W-1:0]   ival_q;
	logic [TIME_W-1:0]   newexp_q;
	logic [CW-1:0]       pos_q;
	logic [ID_W-1:0]     pend_id_q;
	logic                pend_valid_q;
	logic                out_valid_q;
	logic [ID_W-1:0]     out_id_q;
	logic                out_last_q;

	logic [IW-1:0]       pos_idx;
	logic [ID_W-1:0]     pos_id;
	logic [TIME_W-1:0]   pos_exp;
	logic [TIME_W-1:0]   sum_exp;

	assign pos_idx = pos_q[IW-1:0];
	assign pos_id  = order_q[pos_idx];
	assign pos_exp = exp_q[pos_id[IW-1:0]];
	assign sum_exp = time_q + ival_q;

	assign sts.req        = req_q;
	assign sts.id_ok      = int'(id_q) < NUM_SLOTS;
	assign sts.armed      = mask_q[id_q];
	assign sts.pos_match  = (pos_id == id_q);
	assign sts.ins_here   = (pos_q == cnt_q) || (pos_exp >= newexp_q);
	assign sts.head_due   = (cnt_q != '0) && (pos_exp <= time_q);
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.pend_valid = pend_valid_q;
	assign sts.armed_cnt  = CNT_W'(cnt_q);
	assign sts.armed_mask = mask_q;

	assign out_valid  = out_valid_q;
	assign expired_id = out_id_q;
	assign last_flag  = out_last_q;

	// request fields and scratch values
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q  <= req_type;
			id_q   <= timer_id;
			ival_q <= interval;
		end
		if (cmd.set_expiry) begin
			newexp_q              <= sum_exp;
			exp_q[id_q[IW-1:0]]   <= sum_exp;
		end
		if (cmd.capture_pend)
			pend_id_q <= pos_id;
		if (cmd.push_out) begin
			out_id_q   <= pend_id_q;
			out_last_q <= cmd.push_last;
		end
	end

	// ordered id list: close the gap at pos or open one at pos
	always_ff @(posedge clk) begin
		if (cmd.remove_at_pos) begin
			for (int k = 0; k < LIST_DEPTH - 1; k++) begin
				if (CW'(k) >= pos_q)
					order_q[k] <= order_q[k + 1];
			end
		end
		if (cmd.insert_at_pos) begin
			for (int k = 1; k < LIST_DEPTH; k++) begin
				if (CW'(k) > pos_q)
					order_q[k] <= order_q[k - 1];
			end
			order_q[pos_idx] <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q       <= '0;
			cnt_q        <= '0;
			mask_q       <= '0;
			pos_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.time_inc)
				time_q <= time_q + 1'b1;
			if (cmd.pos_clear)
				pos_q <= '0;
			else if (cmd.pos_inc)
				pos_q <= pos_q + 1'b1;
			if (cmd.remove_at_pos) begin
				cnt_q          <= cnt_q - 1'b1;
				mask_q[pos_id] <= 1'b0;
			end else if (cmd.insert_at_pos) begin
				cnt_q        <= cnt_q + 1'b1;
				mask_q[id_q] <= 1'b1;
			end
			if (cmd.capture_pend)
				pend_valid_q <= 1'b1;
			else if (cmd.push_out && cmd.push_last)
				pend_valid_q <= 1'b0;
			if (cmd.push_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ hdl/setq_ctrl.sv @@
`timescale 1ns / 1ps
// setq_ctrl: request sequencer for the timer queue; walks the ordered list one
// entry a cycle and issues datapath commands, uses setq_pkg

module setq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  setq_pkg::ctrl_sts_t sts,
	output setq_pkg::ctrl_cmd_t cmd
);
	import setq_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_DISPATCH  = 3'd1;
	localparam logic [2:0] ST_DROP_SCAN = 3'd2;
	localparam logic [2:0] ST_INS_START = 3'd3;
	localparam logic [2:0] ST_INS_SCAN  = 3'd4;
	localparam logic [2:0] ST_PROC_HEAD = 3'd5;
	localparam logic [2:0] ST_PROC_LAST = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_req = in_valid;
				if (in_valid)
					state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				cmd.pos_clear = 1'b1;
				unique case (sts.req)
					REQ_TICK: begin
						cmd.time_inc = 1'b1;
						state_d      = ST_IDLE;
					end
					REQ_ARM: begin
						if (!sts.id_ok)
							state_d = ST_IDLE;
						else if (sts.armed)
							state_d = ST_DROP_SCAN;
						else
							state_d = ST_INS_START;
					end
					REQ_CANCEL: begin
						if (sts.id_ok && sts.armed)
							state_d = ST_DROP_SCAN;
						else
							state_d = ST_IDLE;
					end
					default: begin
						state_d = ST_PROC_HEAD;
					end
				endcase
			end
			ST_DROP_SCAN: begin
				// armed slot is always in the list, so the scan ends on a match
				if (sts.pos_match) begin
					cmd.remove_at_pos = 1'b1;
					state_d = (sts.req == REQ_ARM) ? ST_INS_START : ST_IDLE;
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			ST_INS_START: begin
				cmd.set_expiry = 1'b1;
				cmd.pos_clear  = 1'b1;
				state_d        = ST_INS_SCAN;
			end
			ST_INS_SCAN: begin
				if (sts.ins_here) begin
					cmd.insert_at_pos = 1'b1;
					state_d           = ST_IDLE;
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			ST_PROC_HEAD: begin
				// pos stays at zero: the head is popped, earlier id goes out unflagged
				if (sts.head_due) begin
					if (!sts.pend_valid || sts.out_free) begin
						cmd.remove_at_pos = 1'b1;
						cmd.capture_pend  = 1'b1;
						cmd.push_out      = sts.pend_valid;
					end
				end else if (sts.pend_valid) begin
					state_d = ST_PROC_LAST;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PROC_LAST: begin
				if (sts.out_free) begin
					cmd.push_out  = 1'b1;
					cmd.push_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

@@ hdl/sorted_expiry_timer_queue_unit.sv @@
`timescale 1ns / 1ps
// sorted_expiry_timer_queue_unit: top level of the timer queue, joins the
// sequencer setq_ctrl and the datapath setq_datapath; uses setq_pkg

// A 32-bit tick counter and up to min(NUM_SLOTS,16) timer slots kept in a list
// ordered by expiry. One request is taken at a time: in_stall is high from the
// cycle after a transfer until the request is done. A cancel of an armed slot
// walks the list up to the slot's position; a cancel of an unarmed slot does
// not walk it. An arm walks to the insert position, after first removing the
// slot the same way when it was already armed. A process pops the expired slots
// from the head, and waits while out_stall holds the result register. The insert
// walk compares one entry against the new expiry per cycle. Results leave
// through a single output register, so the next request is taken while the
// last id still waits for its transfer.

module sorted_expiry_timer_queue_unit #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [setq_pkg::REQ_W-1:0]    req_type,
	input  logic [setq_pkg::ID_W-1:0]     timer_id,
	input  logic [setq_pkg::TIME_W-1:0]   interval,
	// expired id channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [setq_pkg::ID_W-1:0]     expired_id,
	output logic                          last_flag
);
	import setq_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// sequencer: one state per phase of a request, list walk one entry a cycle
	setq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage, compare logic and result register
	setq_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req_type),
		.timer_id   (timer_id),
		.interval   (interval),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.expired_id (expired_id),
		.last_flag  (last_flag)
	);

	// a result is loaded only when the register is empty or being drained
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_out |-> sts.out_free)
		else $error("result register overwritten before its transfer");

	// the armed count always matches the number of armed slots
	a_count_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(sts.armed_mask) == int'(sts.armed_cnt))
		else $error("armed count and armed mask disagree");

	// a held id only exists while a process request is in flight
	a_pend_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.pend_valid |-> in_stall)
		else $error("pending expired id left behind after request end");

	// the list never takes a slot that is already armed
	a_insert_unarmed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert_at_pos |-> !sts.armed)
		else $error("insert of a slot that is still in the list");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for sorted_expiry_timer_queue_unit, with an expiry list
// predictor in a scoreboard class, request tasks, receiver processes; uses setq_pkg

module tb;
	import setq_pkg::*;

	localparam int NUM_SLOTS = 16;
	// long receiver hold-off so that the request side backs up
	localparam int LONG_HOLD = 300;
	// settle cycles after the last expected id, longer than any request
	localparam int SETTLE_CYCLES = 60;

	// one expected expired id with its end-of-burst flag
	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            last;
	} due_id_t;

	// mirrors the timer list and queues the ids each process request should emit
	class expiry_scoreboard;
		int unsigned         slot_limit;
		int unsigned         list_depth;
		logic [TIME_W-1:0]   now_ms;
		logic [TIME_W-1:0]   deadline [ID_SPACE];
		logic [ID_W-1:0]     deadline_order [ID_SPACE];
		int unsigned         armed_total;
		logic [ID_SPACE-1:0] armed_bits;
		due_id_t             due_ids [$];
		int unsigned         mismatches;
		int unsigned         ids_checked;
		int unsigned         largest_burst;
		int unsigned         req_hist [4];

		function new(int unsigned slots);
			slot_limit    = slots;
			list_depth    = (slots < ID_SPACE) ? slots : ID_SPACE;
			now_ms        = '0;
			armed_total   = 0;
			armed_bits    = '0;
			mismatches    = 0;
			ids_checked   = 0;
			largest_burst = 0;
			foreach (req_hist[i]) req_hist[i] = 0;
		endfunction

		// take a slot out of the list, nothing if it is not armed
		function void unlink_slot(logic [ID_W-1:0] id);
			int unsigned pos;
			if (!armed_bits[id])
				return;
			pos = 0;
			while (pos < armed_total && deadline_order[pos] != id) pos++;
			for (int unsigned k = pos; k + 1 < armed_total; k++)
				deadline_order[k] = deadline_order[k + 1];
			if (armed_total > 0)
				armed_total--;
			armed_bits[id] = 1'b0;
		endfunction

		function void link_slot(logic [ID_W-1:0] id, logic [TIME_W-1:0] span);
			logic [TIME_W-1:0] due;
			int unsigned       pos;
			unlink_slot(id);
			due          = now_ms + span;
			deadline[id] = due;
			pos = 0;
			// equal deadlines: the newest slot goes first
			while (pos < armed_total && deadline[deadline_order[pos]] < due) pos++;
			if (armed_total >= list_depth)
				return;
			for (int unsigned k = armed_total; k > pos; k--)
				deadline_order[k] = deadline_order[k - 1];
			deadline_order[pos] = id;
			armed_total++;
			armed_bits[id] = 1'b1;
		endfunction

		// called once per accepted request transfer
		function void note_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
		                           logic [TIME_W-1:0] span);
			logic [ID_W-1:0] head;
			int unsigned     burst;
			req_hist[req]++;
			case (req)
				REQ_TICK: begin
					now_ms = now_ms + 1'b1;
				end
				REQ_ARM: begin
					if (id < slot_limit)
						link_slot(id, span);
				end
				REQ_CANCEL: begin
					if (id < slot_limit)
						unlink_slot(id);
				end
				default: begin
					burst = 0;
					while (armed_total > 0 && burst < ID_SPACE) begin
						head = deadline_order[0];
						// plain unsigned compare, wrapped deadlines count as past
						if (deadline[head] > now_ms)
							break;
						for (int unsigned k = 0; k + 1 < armed_total; k++)
							deadline_order[k] = deadline_order[k + 1];
						armed_total--;
						armed_bits[head] = 1'b0;
						due_ids.push_back('{id: head, last: 1'b0});
						burst++;
					end
					if (burst > 0)
						due_ids[due_ids.size() - 1].last = 1'b1;
					if (burst > largest_burst)
						largest_burst = burst;
				end
			endcase
		endfunction

		// called once per accepted expired id transfer
		function void check_expired(logic [ID_W-1:0] id, logic last);
			due_id_t want;
			if (due_ids.size() == 0) begin
				$error("expired_id %0d last_flag %0b arrived with nothing expected", id, last);
				mismatches++;
				return;
			end
			want = due_ids.pop_front();
			ids_checked++;
			if (id !== want.id) begin
				$error("expired_id: expected %0d, got %0d", want.id, id);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last_flag: expected %0b, got %0b", want.last, last);
				mismatches++;
			end
		endfunction

		function void check_leftover();
			if (due_ids.size() != 0) begin
				$error("expired_id: expected %0d more ids, got none", due_ids.size());
				mismatches += due_ids.size();
			end
		endfunction
	endclass

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic [REQ_W-1:0]  req_type   = REQ_TICK;
	logic [ID_W-1:0]   timer_id   = '0;
	logic [TIME_W-1:0] interval   = '0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [ID_W-1:0]   expired_id;
	logic              last_flag;

	expiry_scoreboard sb;

	// idle and stall chances in percent, set per phase
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;

	// hold-off handshake between the stimulus and the receiver process
	int hold_req  = 0;
	int hold_seen = 0;
	int hold_left = 0;

	sorted_expiry_timer_queue_unit #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.timer_id  (timer_id),
		.interval  (interval),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.expired_id(expired_id),
		.last_flag (last_flag)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, or a long hold-off when the stimulus asks for one
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// every expired id transfer is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_expired(expired_id, last_flag);
	end

	// one request transfer, with a random idle gap ahead of it
	task automatic send_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
	                            input logic [TIME_W-1:0] span);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		timer_id <= id;
		interval <= span;
		do @(posedge clk); while (in_stall);
		sb.note_request(req, id, span);
	endtask

	// sender stops offering until every predicted id has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.due_ids.size() != 0) @(posedge clk);
	endtask

	// mostly short intervals so timers expire, plus full range and wrapping ones
	function automatic logic [TIME_W-1:0] pick_interval();
		int k;
		k = $urandom_range(99);
		if (k < 70)
			return TIME_W'($urandom_range(12));
		else if (k < 85)
			return $urandom();
		else
			return 32'hFFFF_FFFF - TIME_W'($urandom_range(8));
	endfunction

	task automatic send_random(int count);
		int              r;
		logic [REQ_W-1:0] req;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 35)
				req = REQ_TICK;
			else if (r < 65)
				req = REQ_ARM;
			else if (r < 75)
				req = REQ_CANCEL;
			else
				req = REQ_PROCESS;
			send_request(req, ID_W'($urandom_range(15)), pick_interval());
		end
	endtask

	// arm every slot in shuffled order close to now, then flush them in one burst
	task automatic fill_and_flush();
		logic [ID_W-1:0] ids [ID_SPACE];
		logic [ID_W-1:0] swap;
		int              j;
		foreach (ids[i]) ids[i] = ID_W'(i);
		for (int i = ID_SPACE - 1; i > 0; i--) begin
			j       = $urandom_range(i);
			swap    = ids[i];
			ids[i]  = ids[j];
			ids[j]  = swap;
		end
		foreach (ids[i]) send_request(REQ_ARM, ids[i], TIME_W'($urandom_range(1)));
		send_request(REQ_TICK, '0, $urandom());
		send_request(REQ_TICK, '0, $urandom());
		send_request(REQ_PROCESS, '0, $urandom());
	endtask

	task automatic set_idling(int sender_pct, int receiver_pct);
		sender_idle_pct    = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	initial begin
		sb = new(NUM_SLOTS);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: wrapped deadline, zero interval, equal deadlines, re-arm,
		// cancel of an unarmed slot, process with nothing due
		set_idling(0, 0);
		send_request(REQ_TICK, 4'd0, 32'd0);
		send_request(REQ_ARM, 4'd15, 32'hFFFF_FFFF);
		send_request(REQ_ARM, 4'd3, 32'd2);
		send_request(REQ_ARM, 4'd7, 32'd2);
		send_request(REQ_ARM, 4'd3, 32'd1);
		send_request(REQ_CANCEL, 4'd9, 32'hFFFF_FFFF);
		send_request(REQ_CANCEL, 4'd7, 32'd0);
		send_request(REQ_PROCESS, 4'd0, 32'd0);
		send_request(REQ_TICK, 4'd0, 32'd0);
		send_request(REQ_ARM, 4'd2, 32'd0);
		send_request(REQ_PROCESS, 4'd15, 32'hFFFF_FFFF);
		send_request(REQ_PROCESS, 4'd0, 32'd0);
		send_request(REQ_ARM, 4'd5, 32'd4);
		send_request(REQ_ARM, 4'd6, 32'd4);
		repeat (4) send_request(REQ_TICK, 4'd0, 32'd0);
		send_request(REQ_PROCESS, 4'd0, 32'd0);
		send_request(REQ_ARM, 4'd0, 32'h8000_0000);
		send_request(REQ_CANCEL, 4'd0, 32'd0);
		wait_drained();

		// random phase without idling, with a full sixteen-id burst
		send_random(40);
		fill_and_flush();
		wait_drained();

		// sender idles most cycles
		set_idling(72, 0);
		send_random(55);
		wait_drained();

		// receiver stalls most cycles
		set_idling(0, 72);
		send_random(35);
		fill_and_flush();
		wait_drained();

		// long receiver hold-off while requests keep coming
		set_idling(0, 0);
		hold_req <= hold_req + 1;
		for (int i = 0; i < 4; i++) send_request(REQ_ARM, ID_W'($urandom_range(15)), 32'd0);
		send_request(REQ_PROCESS, '0, $urandom());
		send_random(15);
		wait_drained();

		// light idling on both sides
		set_idling(10, 10);
		send_random(50);
		wait_drained();

		set_idling(0, 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.check_leftover();

		$display("covered %0d requests: %0d ticks, %0d arms, %0d cancels, %0d processes",
		         sb.req_hist[REQ_TICK] + sb.req_hist[REQ_ARM] + sb.req_hist[REQ_CANCEL]
		         + sb.req_hist[REQ_PROCESS], sb.req_hist[REQ_TICK], sb.req_hist[REQ_ARM],
		         sb.req_hist[REQ_CANCEL], sb.req_hist[REQ_PROCESS]);
		$display("checked %0d expired ids, longest burst %0d ids",
		         sb.ids_checked, sb.largest_burst);
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/setq_pkg.sv
hdl/setq_datapath.sv
hdl/setq_ctrl.sv
hdl/sorted_expiry_timer_queue_unit.sv
bench/tb.sv
